// ===== design/triangle_raster_msaa_zbuffer_macros.svh =====
// Assertion macros used by the rasteriser back end
`ifndef TRIANGLE_RASTER_MSAA_ZBUFFER_MACROS_SVH
`define TRIANGLE_RASTER_MSAA_ZBUFFER_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define TRMZ_ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("trmz: implication failed");

// next-cycle implication
`define TRMZ_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("trmz: next-cycle check failed");

`endif

// ===== design/trmz_pkg.sv =====
// Shared constants, command codes and types for the rasteriser
package trmz_pkg;
    localparam int WIDTH     = 64;
    localparam int HEIGHT    = 64;
    localparam int FRAC_BITS = 4;

    localparam int NPIX  = WIDTH * HEIGHT;
    localparam int NSAMP = 4 * NPIX;
    localparam int XW    = $clog2(WIDTH);
    localparam int YW    = $clog2(HEIGHT);
    localparam int SAW   = $clog2(NSAMP);

    localparam int CW    = 12;                  // vertex coordinate width
    localparam int UBW   = CW - 1 - FRAC_BITS;  // integer part of a non-negative coord
    localparam int BXW   = (UBW > XW ? UBW : XW);
    localparam int BYW   = (UBW > YW ? UBW : YW);
    localparam int MXY   = (XW > YW ? XW : YW);
    localparam int PW    = ((MXY + FRAC_BITS > CW - 1) ? MXY + FRAC_BITS : CW - 1) + 1;
    localparam int DFW   = PW + 1;              // coordinate difference
    localparam int EW    = 2 * DFW + 1;         // edge function
    localparam int NW    = EW + 18;             // depth numerator
    localparam int ZW    = 16;
    localparam int COLW  = 24;
    localparam int QD    = 2;
    localparam int QAW   = $clog2(QD);

    localparam logic [ZW-1:0] FAR_DEPTH = '1;

    localparam logic [2:0] FN_DRAW    = 3'd0;
    localparam logic [2:0] FN_CLR_COL = 3'd1;
    localparam logic [2:0] FN_CLR_DEP = 3'd2;
    localparam logic [2:0] FN_CLR_ALL = 3'd3;
    localparam logic [2:0] FN_READ    = 3'd4;

    localparam logic [1:0] OP_NOP   = 2'd0;
    localparam logic [1:0] OP_DRAW  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    typedef struct packed {
        logic [1:0]           op;
        logic                 clr_col;
        logic                 clr_dep;
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by_coord;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic [ZW-1:0]        az;
        logic [ZW-1:0]        bz;
        logic [ZW-1:0]        cz;
        logic [COLW-1:0]      col;
        logic [XW-1:0]        left;
        logic [XW-1:0]        right;
        logic [YW-1:0]        bottom;
        logic [YW-1:0]        top;
        logic [11:0]          pixel;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;
endpackage

// ===== design/trmz_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module trmz_ram #(
    parameter int DW    = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DW-1:0]            i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DW-1:0]            o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/trmz_front.sv =====
// Command front end: decode, bounding box and screen clipping
module trmz_front (
    input  logic [2:0]           i_func,
    input  logic signed [11:0]   i_ax,
    input  logic signed [11:0]   i_ay,
    input  logic [15:0]          i_az,
    input  logic signed [11:0]   i_bx,
    input  logic signed [11:0]   i_by_coord,
    input  logic [15:0]          i_bz,
    input  logic signed [11:0]   i_cx,
    input  logic signed [11:0]   i_cy,
    input  logic [15:0]          i_cz,
    input  logic [23:0]          i_tri_color,
    input  logic [11:0]          i_pixel_index,
    output trmz_pkg::t_cmd       o_cmd
);
    import trmz_pkg::*;

    logic signed [CW-1:0] lo_x, hi_x, lo_y, hi_y, m_x, m_y;
    logic [BXW-1:0]       left_e, right_e, right_c;
    logic [BYW-1:0]       bot_e, top_e, top_c;
    logic                 box_empty;
    t_cmd                 cmd;

    always_comb begin
        m_x  = (i_ax < i_bx) ? i_ax : i_bx;
        lo_x = (m_x < i_cx) ? m_x : i_cx;
        m_x  = (i_ax > i_bx) ? i_ax : i_bx;
        hi_x = (m_x > i_cx) ? m_x : i_cx;
        m_y  = (i_ay < i_by_coord) ? i_ay : i_by_coord;
        lo_y = (m_y < i_cy) ? m_y : i_cy;
        m_y  = (i_ay > i_by_coord) ? i_ay : i_by_coord;
        hi_y = (m_y > i_cy) ? m_y : i_cy;

        left_e  = lo_x[CW-1] ? '0 : BXW'(lo_x[CW-2:FRAC_BITS]);
        bot_e   = lo_y[CW-1] ? '0 : BYW'(lo_y[CW-2:FRAC_BITS]);
        right_e = BXW'(hi_x[CW-2:FRAC_BITS]);
        top_e   = BYW'(hi_y[CW-2:FRAC_BITS]);
        right_c = (right_e > BXW'(WIDTH - 1)) ? BXW'(WIDTH - 1) : right_e;
        top_c   = (top_e > BYW'(HEIGHT - 1)) ? BYW'(HEIGHT - 1) : top_e;

        // wholly left of or below the screen, or box starting past its far edge
        box_empty = hi_x[CW-1] || hi_y[CW-1] || (left_e > right_c) || (bot_e > top_c);

        cmd          = '0;
        cmd.ax       = i_ax;
        cmd.ay       = i_ay;
        cmd.bx       = i_bx;
        cmd.by_coord = i_by_coord;
        cmd.cx       = i_cx;
        cmd.cy       = i_cy;
        cmd.az       = i_az;
        cmd.bz       = i_bz;
        cmd.cz       = i_cz;
        cmd.col      = i_tri_color;
        cmd.left     = left_e[XW-1:0];
        cmd.right    = right_c[XW-1:0];
        cmd.bottom   = bot_e[YW-1:0];
        cmd.top      = top_c[YW-1:0];
        cmd.pixel    = i_pixel_index;

        case (i_func) inside
            FN_DRAW: begin
                cmd.op = box_empty ? OP_NOP : OP_DRAW;
            end
            FN_CLR_COL, FN_CLR_DEP, FN_CLR_ALL: begin
                cmd.op      = OP_CLEAR;
                cmd.clr_col = i_func[0];
                cmd.clr_dep = i_func[1];
            end
            FN_READ: begin
                cmd.op = (int'(i_pixel_index) < NPIX) ? OP_READ : OP_NOP;
            end
            default: begin
                cmd.op = OP_NOP;
            end
        endcase
    end

    assign o_cmd = cmd;
endmodule

// ===== design/trmz_queue.sv =====
// Two-entry command queue between front end and back end
module trmz_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  trmz_pkg::t_cmd   i_cmd,
    input  logic             i_pop,
    output trmz_pkg::t_cmd   o_cmd,
    output trmz_pkg::t_qstat o_stat
);
    import trmz_pkg::*;

    t_cmd           r_mem [QD];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_cmd;
                r_wp        <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QAW+1)'(i_push) - (QAW+1)'(i_pop);
        end
    end

    assign o_cmd        = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == (QAW+1)'(QD));
    assign o_stat.empty = (r_cnt == '0);
endmodule

// ===== design/trmz_back.sv =====
// Back end: sample walk, depth interpolation and test, clears and pixel reads
module trmz_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  trmz_pkg::t_cmd   i_cmd,
    input  trmz_pkg::t_qstat i_qstat,
    output logic             o_pop,
    output logic             o_init,
    output logic             o_valid,
    output logic [9:0]       o_red_quarters,
    output logic [9:0]       o_green_quarters,
    output logic [9:0]       o_blue_quarters,
    output logic [14:0]      o_samples_updated
);
    import trmz_pkg::*;

`include "triangle_raster_msaa_zbuffer_macros.svh"

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_MUL  = 4'd2;
    localparam logic [3:0] S_EDGE = 4'd3;
    localparam logic [3:0] S_WGT  = 4'd4;
    localparam logic [3:0] S_SUM  = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_TEST = 4'd7;
    localparam logic [3:0] S_NEXT = 4'd8;
    localparam logic [3:0] S_READ = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    logic [3:0]             r_state;
    logic                   r_init, r_clr_col, r_clr_dep, r_valid;
    logic [SAW-1:0]         r_caddr, r_saddr, r_base;
    t_cmd                   r_cmd;
    logic [XW-1:0]          r_x;
    logic [YW-1:0]          r_y;
    logic [1:0]             r_i;
    logic signed [2*DFW-1:0] r_pr [6];
    logic [EW-2:0]          r_wa, r_wb, r_wc;
    logic [EW+14:0]         r_m0, r_m1, r_m2;
    logic [NW-1:0]          r_rem, r_dsh;
    logic [3:0]             r_dcnt;
    logic [ZW-1:0]          r_q;
    logic [14:0]            r_cnt;
    logic [2:0]             r_k;
    logic [9:0]             r_sr, r_sg, r_sb;

    logic signed [PW-1:0]   px, py;
    logic signed [DFW-1:0]  ax_d, ay_d, bx_d, by_d, cx_d, cy_d, px_d, py_d;
    logic signed [EW-1:0]   ea, eb, ec;
    logic                   all_pos, all_neg;
    logic [PW-1:0]          pix_row;
    logic [NW-1:0]          num, nround;
    logic [EW:0]            dsum;
    logic                   pass, dep_we, col_we;
    logic [SAW-1:0]         waddr, col_raddr;
    logic [ZW-1:0]          dep_wdata, dep_rdata;
    logic [COLW-1:0]        col_wdata, col_rdata;

    // sample point: pixel corner plus quarter offsets (1,1) (1,3) (3,1) (3,3)
    always_comb begin
        px   = (PW'(r_x) <<< FRAC_BITS) + (PW'(r_i[1] ? 2'd3 : 2'd1) <<< (FRAC_BITS - 2));
        py   = (PW'(r_y) <<< FRAC_BITS) + (PW'(r_i[0] ? 2'd3 : 2'd1) <<< (FRAC_BITS - 2));
        ax_d = DFW'(r_cmd.ax);
        ay_d = DFW'(r_cmd.ay);
        bx_d = DFW'(r_cmd.bx);
        by_d = DFW'(r_cmd.by_coord);
        cx_d = DFW'(r_cmd.cx);
        cy_d = DFW'(r_cmd.cy);
        px_d = DFW'(px);
        py_d = DFW'(py);
        ec   = EW'(r_pr[0]) - EW'(r_pr[1]);
        ea   = EW'(r_pr[2]) - EW'(r_pr[3]);
        eb   = EW'(r_pr[4]) - EW'(r_pr[5]);
        all_pos = (ea > 0) && (eb > 0) && (ec > 0);
        all_neg = ea[EW-1] && eb[EW-1] && ec[EW-1];
        pix_row = PW'(YW'(HEIGHT - 1) - r_y);
        dsum    = (EW+1)'(r_wa) + (EW+1)'(r_wb) + (EW+1)'(r_wc);
        num     = NW'(r_m0) + NW'(r_m1) + NW'(r_m2);
        nround  = num + NW'(dsum >> 1);
    end

    assign pass      = (r_q < dep_rdata);
    assign dep_we    = ((r_state == S_CLR) && r_clr_dep) || ((r_state == S_TEST) && pass);
    assign col_we    = ((r_state == S_CLR) && r_clr_col) || ((r_state == S_TEST) && pass);
    assign waddr     = (r_state == S_CLR) ? r_caddr : r_saddr;
    assign dep_wdata = (r_state == S_CLR) ? FAR_DEPTH : r_q;
    assign col_wdata = (r_state == S_CLR) ? '0 : r_cmd.col;
    assign col_raddr = r_base | SAW'(r_k[1:0]);
    assign o_pop     = (r_state == S_IDLE) && !i_qstat.empty;

    trmz_ram #(.DW(ZW), .DEPTH(NSAMP)) u_depth (
        .i_clk   (i_clk),
        .i_we    (dep_we),
        .i_waddr (waddr),
        .i_wdata (dep_wdata),
        .i_raddr (r_saddr),
        .o_rdata (dep_rdata)
    );

    trmz_ram #(.DW(COLW), .DEPTH(NSAMP)) u_colour (
        .i_clk   (i_clk),
        .i_we    (col_we),
        .i_waddr (waddr),
        .i_wdata (col_wdata),
        .i_raddr (col_raddr),
        .o_rdata (col_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_init    <= 1'b1;
            r_clr_col <= 1'b1;
            r_clr_dep <= 1'b1;
            r_caddr   <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_CLR: begin
                    r_caddr <= r_caddr + 1'b1;
                    if (r_caddr == SAW'(NSAMP - 1)) begin
                        r_state <= r_init ? S_IDLE : S_DONE;
                        r_init  <= 1'b0;
                    end
                end
                S_IDLE: begin
                    if (!i_qstat.empty) begin
                        r_cmd     <= i_cmd;
                        r_cnt     <= '0;
                        r_sr      <= '0;
                        r_sg      <= '0;
                        r_sb      <= '0;
                        r_x       <= i_cmd.left;
                        r_y       <= i_cmd.bottom;
                        r_i       <= '0;
                        r_caddr   <= '0;
                        r_clr_col <= i_cmd.clr_col;
                        r_clr_dep <= i_cmd.clr_dep;
                        r_k       <= '0;
                        r_base    <= SAW'(i_cmd.pixel) << 2;
                        case (i_cmd.op)
                            OP_DRAW:  r_state <= S_MUL;
                            OP_CLEAR: r_state <= S_CLR;
                            OP_READ:  r_state <= S_READ;
                            default:  r_state <= S_DONE;
                        endcase
                    end
                end
                S_MUL: begin
                    r_pr[0] <= (bx_d - ax_d) * (py_d - ay_d);
                    r_pr[1] <= (by_d - ay_d) * (px_d - ax_d);
                    r_pr[2] <= (cx_d - bx_d) * (py_d - by_d);
                    r_pr[3] <= (cy_d - by_d) * (px_d - bx_d);
                    r_pr[4] <= (ax_d - cx_d) * (py_d - cy_d);
                    r_pr[5] <= (ay_d - cy_d) * (px_d - cx_d);
                    r_saddr <= SAW'({SAW'(pix_row * PW'(WIDTH) + PW'(r_x)), r_i});
                    r_state <= S_EDGE;
                end
                S_EDGE: begin
                    r_wa    <= (EW-1)'(all_neg ? -ea : ea);
                    r_wb    <= (EW-1)'(all_neg ? -eb : eb);
                    r_wc    <= (EW-1)'(all_neg ? -ec : ec);
                    r_state <= (all_pos || all_neg) ? S_WGT : S_NEXT;
                end
                S_WGT: begin
                    r_m0    <= r_wa * r_cmd.az;
                    r_m1    <= r_wb * r_cmd.bz;
                    r_m2    <= r_wc * r_cmd.cz;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_rem   <= nround;
                    r_dsh   <= NW'(dsum) << (ZW - 1);
                    r_dcnt  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // restoring division, one quotient bit per cycle, MSB first
                    if (r_rem >= r_dsh) begin
                        r_rem <= r_rem - r_dsh;
                        r_q   <= {r_q[ZW-2:0], 1'b1};
                    end else begin
                        r_q   <= {r_q[ZW-2:0], 1'b0};
                    end
                    r_dsh  <= r_dsh >> 1;
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == 4'(ZW - 1)) begin
                        r_state <= S_TEST;
                    end
                end
                S_TEST: begin
                    if (pass && (r_cnt != 15'h7FFF)) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    r_state <= S_MUL;
                    r_i     <= r_i + 1'b1;
                    if (r_i == 2'd3) begin
                        if (r_y != r_cmd.top) begin
                            r_y <= r_y + 1'b1;
                        end else begin
                            r_y <= r_cmd.bottom;
                            if (r_x != r_cmd.right) begin
                                r_x <= r_x + 1'b1;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                    end
                end
                S_READ: begin
                    // data for sample k-1 arrives while sample k is addressed
                    r_k <= r_k + 1'b1;
                    if (r_k != 3'd0) begin
                        r_sr <= r_sr + 10'(col_rdata[23:16]);
                        r_sg <= r_sg + 10'(col_rdata[15:8]);
                        r_sb <= r_sb + 10'(col_rdata[7:0]);
                    end
                    if (r_k == 3'd4) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_init            = r_init;
    assign o_valid           = r_valid;
    assign o_red_quarters    = r_sr;
    assign o_green_quarters  = r_sg;
    assign o_blue_quarters   = r_sb;
    assign o_samples_updated = r_cnt;

    `TRMZ_ASSERT_NEXT(a_strobe_single, r_valid, !r_valid)
    `TRMZ_ASSERT_IMPLY(a_dep_we_state, dep_we, (r_state == S_TEST) || (r_state == S_CLR))
    `TRMZ_ASSERT_IMPLY(a_no_result_init, r_init, !r_valid && !o_pop)
endmodule

// ===== design/triangle_raster_msaa_zbuffer.sv =====
// Draw: each sample goes through the S_MUL, S_EDGE and S_NEXT states; a covered sample
// also goes through weight, sum, the 16-step depth divider and the depth test.
// A full-screen draw has 16384 samples. Clears sweep the sample stores one entry a cycle.
// Pixel read: four registered colour-store reads. Two commands may queue.
// Reset: synchronous; a clearing pass over all 16384 samples follows, busy stays high throughout.
// Results are one-cycle strobes on o_valid and cannot be held off.
module triangle_raster_msaa_zbuffer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [2:0]          i_func,
    input  logic signed [11:0]  i_ax,
    input  logic signed [11:0]  i_ay,
    input  logic [15:0]         i_az,
    input  logic signed [11:0]  i_bx,
    input  logic signed [11:0]  i_by_coord,
    input  logic [15:0]         i_bz,
    input  logic signed [11:0]  i_cx,
    input  logic signed [11:0]  i_cy,
    input  logic [15:0]         i_cz,
    input  logic [23:0]         i_tri_color,
    input  logic [11:0]         i_pixel_index,
    output logic                o_valid,
    output logic [9:0]          o_red_quarters,
    output logic [9:0]          o_green_quarters,
    output logic [9:0]          o_blue_quarters,
    output logic [14:0]         o_samples_updated
);
    import trmz_pkg::*;

    t_cmd   f_cmd, q_cmd;
    t_qstat q_stat;
    logic   push, pop, bk_init;

    assign busy = q_stat.full || bk_init;
    assign push = start && !busy;

    trmz_front u_front (
        .i_func        (i_func),
        .i_ax          (i_ax),
        .i_ay          (i_ay),
        .i_az          (i_az),
        .i_bx          (i_bx),
        .i_by_coord    (i_by_coord),
        .i_bz          (i_bz),
        .i_cx          (i_cx),
        .i_cy          (i_cy),
        .i_cz          (i_cz),
        .i_tri_color   (i_tri_color),
        .i_pixel_index (i_pixel_index),
        .o_cmd         (f_cmd)
    );

    trmz_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .i_pop   (pop),
        .o_cmd   (q_cmd),
        .o_stat  (q_stat)
    );

    trmz_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (q_cmd),
        .i_qstat           (q_stat),
        .o_pop             (pop),
        .o_init            (bk_init),
        .o_valid           (o_valid),
        .o_red_quarters    (o_red_quarters),
        .o_green_quarters  (o_green_quarters),
        .o_blue_quarters   (o_blue_quarters),
        .o_samples_updated (o_samples_updated)
    );
endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the MSAA triangle rasteriser with depth buffer
`timescale 1ns / 100ps

module tb;
    import trmz_pkg::*;

    typedef struct {
        logic [2:0]         func;
        logic signed [11:0] ax, ay, bx, by_coord, cx, cy;
        logic [15:0]        az, bz, cz;
        logic [23:0]        colour;
        logic [11:0]        pixel;
    } t_cmd_in;

    typedef struct {
        logic [9:0]  red, green, blue;
        logic [14:0] updated;
    } t_pix_out;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [2:0]         i_func = '0;
    logic signed [11:0] i_ax = '0, i_ay = '0, i_bx = '0, i_by_coord = '0, i_cx = '0, i_cy = '0;
    logic [15:0]        i_az = '0, i_bz = '0, i_cz = '0;
    logic [23:0]        i_tri_color = '0;
    logic [11:0]        i_pixel_index = '0;
    logic               o_valid;
    logic [9:0]         o_red_quarters, o_green_quarters, o_blue_quarters;
    logic [14:0]        o_samples_updated;

    logic [15:0] depth_mem [NSAMP];
    logic [23:0] colour_mem [NSAMP];
    t_pix_out    pending_q [$];
    int          mismatches = 0;
    bit          idle_on = 1'b1;
    int          last_px = 0, last_py = 0;

    triangle_raster_msaa_zbuffer u_top (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #100ms;
        $display("== FAIL ==");
        $finish;
    end

    function automatic longint edge_val(longint px, longint py, longint qx, longint qy,
                                        longint sx, longint sy);
        return (qx - px) * (sy - py) - (qy - py) * (sx - px);
    endfunction

    function automatic logic [14:0] raster_tri(t_cmd_in c);
        longint x0, y0, x1, y1, x2, y2, lo_x, hi_x, lo_y, hi_y;
        longint left, right, bottom, top, px, py, ea, eb, ec;
        longint unsigned wa, wb, wc, d, num, z;
        int s, cnt;
        int ox [4] = '{1, 1, 3, 3};
        int oy [4] = '{1, 3, 1, 3};
        x0 = longint'(c.ax); y0 = longint'(c.ay); x1 = longint'(c.bx);
        y1 = longint'(c.by_coord); x2 = longint'(c.cx); y2 = longint'(c.cy);
        cnt = 0;
        lo_x = x0 < x1 ? x0 : x1; lo_x = lo_x < x2 ? lo_x : x2;
        hi_x = x0 > x1 ? x0 : x1; hi_x = hi_x > x2 ? hi_x : x2;
        lo_y = y0 < y1 ? y0 : y1; lo_y = lo_y < y2 ? lo_y : y2;
        hi_y = y0 > y1 ? y0 : y1; hi_y = hi_y > y2 ? hi_y : y2;
        if (hi_x < 0 || hi_y < 0) return '0;
        left   = lo_x < 0 ? 0 : lo_x >>> FRAC_BITS;
        bottom = lo_y < 0 ? 0 : lo_y >>> FRAC_BITS;
        right  = hi_x >>> FRAC_BITS;
        top    = hi_y >>> FRAC_BITS;
        if (right > WIDTH - 1) right = WIDTH - 1;
        if (top > HEIGHT - 1) top = HEIGHT - 1;
        for (longint x = left; x <= right; x++) begin
            for (longint y = bottom; y <= top; y++) begin
                for (int i = 0; i < 4; i++) begin
                    px = x * (1 << FRAC_BITS) + ox[i] * (1 << (FRAC_BITS - 2));
                    py = y * (1 << FRAC_BITS) + oy[i] * (1 << (FRAC_BITS - 2));
                    ec = edge_val(x0, y0, x1, y1, px, py);
                    ea = edge_val(x1, y1, x2, y2, px, py);
                    eb = edge_val(x2, y2, x0, y0, px, py);
                    if (ea > 0 && eb > 0 && ec > 0) begin
                        wa = ea; wb = eb; wc = ec;
                    end else if (ea < 0 && eb < 0 && ec < 0) begin
                        wa = -ea; wb = -eb; wc = -ec;
                    end else begin
                        continue;
                    end
                    d   = wa + wb + wc;
                    num = wa * 64'(c.az) + wb * 64'(c.bz) + wc * 64'(c.cz);
                    z   = (num + d / 2) / d;
                    s   = int'(((HEIGHT - 1 - y) * WIDTH + x) * 4 + i);
                    if (z < 64'(depth_mem[s])) begin
                        depth_mem[s]  = z[15:0];
                        colour_mem[s] = c.colour;
                        if (cnt < 32767) cnt++;
                    end
                end
            end
        end
        return cnt[14:0];
    endfunction

    function automatic t_pix_out model_cmd(t_cmd_in c);
        t_pix_out r;
        int rs, gs, bs;
        r = '{default: '0};
        case (c.func)
            FN_DRAW: r.updated = raster_tri(c);
            FN_CLR_COL, FN_CLR_DEP, FN_CLR_ALL: begin
                for (int i = 0; i < NSAMP; i++) begin
                    if (c.func[0]) colour_mem[i] = '0;
                    if (c.func[1]) depth_mem[i] = FAR_DEPTH;
                end
            end
            FN_READ: begin
                rs = 0; gs = 0; bs = 0;
                if (int'(c.pixel) < NPIX) begin
                    for (int i = 0; i < 4; i++) begin
                        rs += int'(colour_mem[int'(c.pixel) * 4 + i][23:16]);
                        gs += int'(colour_mem[int'(c.pixel) * 4 + i][15:8]);
                        bs += int'(colour_mem[int'(c.pixel) * 4 + i][7:0]);
                    end
                end
                r.red = rs[9:0]; r.green = gs[9:0]; r.blue = bs[9:0];
            end
            default: ;
        endcase
        return r;
    endfunction

    // result checker; every command yields exactly one strobe
    always @(posedge i_clk) begin
        t_pix_out e;
        if (i_rst_n && o_valid) begin
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
            end else begin
                e = pending_q.pop_front();
                if (e.red !== o_red_quarters || e.green !== o_green_quarters ||
                    e.blue !== o_blue_quarters || e.updated !== o_samples_updated) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at %0t: exp r%0d g%0d b%0d n%0d got r%0d g%0d b%0d n%0d",
                                 $realtime, e.red, e.green, e.blue, e.updated,
                                 o_red_quarters, o_green_quarters, o_blue_quarters,
                                 o_samples_updated);
                end
            end
        end
    end

    function automatic t_cmd_in rand_cmd(logic [2:0] f);
        t_cmd_in c;
        c.func = f;
        c.ax = 12'($urandom); c.ay = 12'($urandom); c.bx = 12'($urandom);
        c.by_coord = 12'($urandom); c.cx = 12'($urandom); c.cy = 12'($urandom);
        c.az = 16'($urandom_range(0, 65534)); c.bz = 16'($urandom_range(0, 65534));
        c.cz = 16'($urandom_range(0, 65534));
        c.colour = 24'($urandom); c.pixel = 12'($urandom);
        return c;
    endfunction

    // one command transfer; start stays high unless an idle gap follows
    task automatic send_cmd(t_cmd_in c);
        start <= 1'b1;
        i_func <= c.func;
        i_ax <= c.ax; i_ay <= c.ay; i_az <= c.az;
        i_bx <= c.bx; i_by_coord <= c.by_coord; i_bz <= c.bz;
        i_cx <= c.cx; i_cy <= c.cy; i_cz <= c.cz;
        i_tri_color <= c.colour; i_pixel_index <= c.pixel;
        do @(posedge i_clk); while (busy);
        pending_q.push_back(model_cmd(c));
        if (idle_on && $urandom_range(0, 99) < 12) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic send_tri(int x0, int y0, int x1, int y1, int x2, int y2,
                            int z0, int z1, int z2, int colour);
        t_cmd_in c;
        c = rand_cmd(FN_DRAW);
        c.ax = 12'(x0); c.ay = 12'(y0); c.bx = 12'(x1); c.by_coord = 12'(y1);
        c.cx = 12'(x2); c.cy = 12'(y2);
        c.az = 16'(z0); c.bz = 16'(z1); c.cz = 16'(z2); c.colour = 24'(colour);
        send_cmd(c);
    endtask

    task automatic read_px(int x, int y);
        t_cmd_in c;
        c = rand_cmd(FN_READ);
        c.pixel = 12'((HEIGHT - 1 - y) * WIDTH + x);
        send_cmd(c);
    endtask

    task automatic test_clears_and_reads();
        read_px(0, 0);
        read_px(WIDTH - 1, HEIGHT - 1);
        send_cmd(rand_cmd(3'd5));
        send_cmd(rand_cmd(3'd6));
        send_cmd(rand_cmd(3'd7));
    endtask

    task automatic test_small_triangles();
        // counter-clockwise, then clockwise nearer on top
        send_tri(16, 16, 112, 16, 16, 112, 100, 200, 300, 24'hFF0000);
        send_tri(8, 8, 8, 120, 120, 8, 50, 50, 50, 24'h00FF80);
        send_tri(8, 8, 8, 120, 120, 8, 65535, 65535, 65535, 24'h0000FF); // never nearer
        send_tri(0, 0, 64, 64, 128, 128, 0, 0, 0, 24'hFFFFFF);            // zero area
        send_tri(0, 0, 32, 0, 0, 32, 0, 0, 0, 24'hFFFFFF);                // samples on edges
        send_tri(-2048, -2048, -1, -2048, -2048, -1, 0, 0, 0, 24'h123456); // off screen
        send_tri(-40, 1000, 40, 1000, 0, 1060, 0, 1000, 65534, 24'hABCDEF); // clipped
        read_px(2, 2); read_px(1, 1); read_px(0, 62);
    endtask

    task automatic test_store_clears();
        send_cmd(rand_cmd(FN_CLR_DEP));
        send_tri(8, 8, 120, 8, 8, 120, 900, 900, 900, 24'h808080);
        read_px(1, 1);
        send_cmd(rand_cmd(FN_CLR_COL));
        read_px(1, 1);
        send_cmd(rand_cmd(FN_CLR_ALL));
    endtask

    task automatic test_full_screen();
        send_tri(-2048, -2048, 2047, -2048, -2048, 2047, 0, 65534, 32767, 24'h7F01FE);
        read_px(0, 0); read_px(WIDTH - 1, HEIGHT - 1); read_px(31, 40);
    endtask

    task automatic test_random(int n);
        t_cmd_in c;
        int r, x, y;
        for (int k = 0; k < n; k++) begin
            idle_on = !(k >= 40 && k < 70);
            if (k == 60) drain();
            r = $urandom_range(0, 99);
            if (r < 45) begin
                c = rand_cmd(FN_DRAW);
                x = int'($urandom_range(0, 1080)) - 40;
                y = int'($urandom_range(0, 1080)) - 40;
                c.ax = 12'(x + int'($urandom_range(0, 96)));
                c.ay = 12'(y + int'($urandom_range(0, 96)));
                c.bx = 12'(x + int'($urandom_range(0, 96)));
                c.by_coord = 12'(y + int'($urandom_range(0, 96)));
                c.cx = 12'(x + int'($urandom_range(0, 96)));
                c.cy = 12'(y + int'($urandom_range(0, 96)));
                if ($urandom_range(0, 9) == 0) c.az = 16'hFFFF;
                last_px = (x < 0 ? 0 : x) >> FRAC_BITS;
                last_py = (y < 0 ? 0 : y) >> FRAC_BITS;
            end else if (r < 55) begin
                // off-screen noise with full-range coordinates
                c = rand_cmd(FN_DRAW);
                if ($urandom_range(0, 1)) begin
                    c.ax = 12'(-int'($urandom_range(1, 2048)));
                    c.bx = 12'(-int'($urandom_range(1, 2048)));
                    c.cx = 12'(-int'($urandom_range(1, 2048)));
                end else begin
                    c.ax = 12'($urandom_range(1024, 2047));
                    c.bx = 12'($urandom_range(1024, 2047));
                    c.cx = 12'($urandom_range(1024, 2047));
                end
            end else if (r < 85) begin
                c = rand_cmd(FN_READ);
                x = last_px + int'($urandom_range(0, 7));
                y = last_py + int'($urandom_range(0, 7));
                if (x > WIDTH - 1) x = WIDTH - 1;
                if (y > HEIGHT - 1) y = HEIGHT - 1;
                c.pixel = 12'((HEIGHT - 1 - y) * WIDTH + x);
            end else if (r < 93) begin
                c = rand_cmd(FN_READ);
            end else if (r < 96) begin
                c = rand_cmd(3'($urandom_range(1, 3)));
            end else begin
                c = rand_cmd(3'($urandom_range(5, 7)));
            end
            send_cmd(c);
        end
        idle_on = 1'b1;
    endtask

    initial begin
        for (int i = 0; i < NSAMP; i++) begin
            depth_mem[i]  = FAR_DEPTH;
            colour_mem[i] = '0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_clears_and_reads();
        test_small_triangles();
        test_store_clears();
        test_full_screen();
        test_random(120);
        drain();
        if (mismatches == 0 && pending_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
